FILE: hw/rtl/equatorial_to_horizontal_defines.svh
// ----------------------------------------------------------------------------
// equatorial_to_horizontal assertion macros
// shared concurrent checks, clocked on i_clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef EQUATORIAL_TO_HORIZONTAL_DEFINES_SVH
`define EQUATORIAL_TO_HORIZONTAL_DEFINES_SVH

// same-cycle implication
`define E2H_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("e2h check failed");

// implication after a fixed number of cycles
`define E2H_ASSERT_AFTER(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("e2h check failed");

`endif

FILE: hw/rtl/e2h_pkg.sv
// ----------------------------------------------------------------------------
// e2h_pkg
// angle constants, cordic gain and arctangent table for the coordinate converter
// ----------------------------------------------------------------------------
package e2h_pkg;

    localparam logic [63:0] HALF_TURN       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QUARTER_TURN    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] EIGHTH_TURN     = 64'h2000_0000_0000_0000;
    localparam logic [63:0] KINV_Q62        = 64'd2800459870029452965;
    localparam logic [63:0] TWO_OVER_PI_Q62 = 64'h28BE_60DB_9391_054A;
    // gain-compensated unit length, q60
    localparam logic signed [63:0] UNIT_Q60 = $signed(KINV_Q62 >> 2);

    // atan(2^-idx) in q64 turns, low bits cleared below angle_bits
    function automatic logic [63:0] atan_entry(input int idx, input int angle_bits);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  mask;
        logic [127:0] prod;
        int           w;
        begin
            sum  = 64'd0;
            mask = ~64'd0 << (64 - angle_bits);
            if (idx == 0) begin
                return EIGHTH_TURN & mask;
            end
            for (int k = 0; k < 32; k++) begin
                w = idx * (2 * k + 1);
                if (w <= 62) begin
                    term = (64'd1 << (62 - w)) / 64'(2 * k + 1);
                    if (k[0]) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            prod = {64'd0, sum} * {64'd0, TWO_OVER_PI_Q62};
            return prod[125:62] & mask;
        end
    endfunction

endpackage

FILE: hw/rtl/e2h_cell.sv
// ----------------------------------------------------------------------------
// e2h_cell
// one cordic micro-rotation, rotation or vectoring mode, registered outputs
// ----------------------------------------------------------------------------
module e2h_cell #(
    parameter bit          VECTOR = 1'b0,
    parameter int          SHIFT  = 0,
    parameter logic [63:0] ENTRY  = 64'd0,
    parameter int          PW     = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic [63:0]        i_ang,
    input  logic [PW-1:0]      i_pass,
    output logic               o_vld,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic [63:0]        o_ang,
    output logic [PW-1:0]      o_pass
);

    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic               turn_neg;
    logic signed [63:0] n_x;
    logic signed [63:0] n_y;
    logic [63:0]        n_ang;
    logic               r_vld;
    logic signed [63:0] r_x;
    logic signed [63:0] r_y;
    logic [63:0]        r_ang;
    logic [PW-1:0]      r_pass;

    assign dx = i_y >>> SHIFT;
    assign dy = i_x >>> SHIFT;

    // vectoring drives y toward zero, rotation drives the residual angle
    assign turn_neg = VECTOR ? !i_y[63] : i_ang[63];

    always_comb begin
        if (turn_neg) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_ang = i_ang + ENTRY;
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_ang = i_ang - ENTRY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_ang  <= n_ang;
        r_pass <= i_pass;
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_ang  = r_ang;
    assign o_pass = r_pass;

endmodule

FILE: hw/rtl/e2h_chain.sv
// ----------------------------------------------------------------------------
// e2h_chain
// quadrant or half-plane pre-step followed by a row of cordic cells
// ----------------------------------------------------------------------------
module e2h_chain import e2h_pkg::*; #(
    parameter bit VECTOR     = 1'b0,
    parameter int STAGES     = 28,
    parameter int ANGLE_BITS = 32,
    parameter int PW         = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic [63:0]        i_ang,
    input  logic [PW-1:0]      i_pass,
    output logic               o_vld,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic [63:0]        o_ang,
    output logic [PW-1:0]      o_pass
);

    // vectoring carries a zero flag and the angle offset next to the payload
    localparam int IW = VECTOR ? PW + 65 : PW;

    logic signed [63:0] n_x;
    logic signed [63:0] n_y;
    logic [63:0]        n_ang;
    logic [IW-1:0]      n_pass;
    logic               r_vld;
    logic signed [63:0] r_x;
    logic signed [63:0] r_y;
    logic [63:0]        r_ang;
    logic [IW-1:0]      r_pass;

    logic               c_vld  [0:STAGES];
    logic signed [63:0] c_x    [0:STAGES];
    logic signed [63:0] c_y    [0:STAGES];
    logic [63:0]        c_ang  [0:STAGES];
    logic [IW-1:0]      c_pass [0:STAGES];

    generate
        if (VECTOR) begin : g_vec_pre
            logic is_zero;
            assign is_zero = (i_x == 64'sd0) && (i_y == 64'sd0);
            always_comb begin
                n_pass = {i_pass, is_zero, i_ang};
                if (i_x[63]) begin
                    n_x   = -i_x;
                    n_y   = -i_y;
                    n_ang = i_ang + HALF_TURN;
                end else begin
                    n_x   = i_x;
                    n_y   = i_y;
                    n_ang = i_ang;
                end
            end
        end else begin : g_rot_pre
            logic [63:0] biased;
            logic [1:0]  quad;
            assign biased = i_ang + EIGHTH_TURN;
            assign quad   = biased[63:62];
            always_comb begin
                n_pass = i_pass;
                n_ang  = i_ang - {quad, 62'd0};
                case (quad)
                    2'd1: begin
                        n_x = -i_y;
                        n_y = i_x;
                    end
                    2'd2: begin
                        n_x = -i_x;
                        n_y = -i_y;
                    end
                    2'd3: begin
                        n_x = i_y;
                        n_y = -i_x;
                    end
                    default: begin
                        n_x = i_x;
                        n_y = i_y;
                    end
                endcase
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_ang  <= n_ang;
        r_pass <= n_pass;
    end

    assign c_vld[0]  = r_vld;
    assign c_x[0]    = r_x;
    assign c_y[0]    = r_y;
    assign c_ang[0]  = r_ang;
    assign c_pass[0] = r_pass;

    generate
        for (genvar g = 0; g < STAGES; g++) begin : g_cell
            e2h_cell #(
                .VECTOR (VECTOR),
                .SHIFT  (g),
                .ENTRY  (atan_entry(g, ANGLE_BITS)),
                .PW     (IW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_vld  (c_vld[g]),
                .i_x    (c_x[g]),
                .i_y    (c_y[g]),
                .i_ang  (c_ang[g]),
                .i_pass (c_pass[g]),
                .o_vld  (c_vld[g+1]),
                .o_x    (c_x[g+1]),
                .o_y    (c_y[g+1]),
                .o_ang  (c_ang[g+1]),
                .o_pass (c_pass[g+1])
            );
        end
    endgenerate

    assign o_vld = c_vld[STAGES];
    assign o_x   = c_x[STAGES];
    assign o_y   = c_y[STAGES];

    generate
        if (VECTOR) begin : g_vec_out
            // zero vector: angle is the bare offset
            assign o_ang  = c_pass[STAGES][64] ? c_pass[STAGES][63:0] : c_ang[STAGES];
            assign o_pass = c_pass[STAGES][IW-1:65];
        end else begin : g_rot_out
            assign o_ang  = c_ang[STAGES];
            assign o_pass = c_pass[STAGES];
        end
    endgenerate

endmodule

FILE: hw/rtl/e2h_scale.sv
// ----------------------------------------------------------------------------
// e2h_scale
// four-stage cordic gain compensation, magnitude truncated toward zero
// ----------------------------------------------------------------------------
module e2h_scale import e2h_pkg::*; #(
    parameter int PW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [63:0] i_a,
    input  logic [PW-1:0]      i_pass,
    output logic               o_vld,
    output logic signed [63:0] o_r,
    output logic [PW-1:0]      o_pass
);

    logic [3:0]    r_vld;
    logic [PW-1:0] r_pass [0:3];
    logic [3:0]    r_neg;
    logic [63:0]   r_mag;
    logic [63:0]   r_p0;
    logic [63:0]   r_p1;
    logic [63:0]   r_p2;
    logic [63:0]   r_p3;
    logic [63:0]   r_prod;
    logic [63:0]   r_res;
    logic [127:0]  n_full;

    // q62 product of the magnitude, bits 125..62 of the full sum
    assign n_full = {64'd0, r_p0} + ({64'd0, r_p1} << 32) + ({64'd0, r_p2} << 32)
                  + {r_p3, 64'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass[0] <= i_pass;
        r_pass[1] <= r_pass[0];
        r_pass[2] <= r_pass[1];
        r_pass[3] <= r_pass[2];
        r_neg     <= {r_neg[2:0], i_a[63]};
        r_mag     <= i_a[63] ? 64'd0 - i_a : i_a;
        r_p0      <= {32'd0, r_mag[31:0]}  * {32'd0, KINV_Q62[31:0]};
        r_p1      <= {32'd0, r_mag[31:0]}  * {32'd0, KINV_Q62[63:32]};
        r_p2      <= {32'd0, r_mag[63:32]} * {32'd0, KINV_Q62[31:0]};
        r_p3      <= {32'd0, r_mag[63:32]} * {32'd0, KINV_Q62[63:32]};
        r_prod    <= n_full[125:62];
        r_res     <= r_neg[2] ? 64'd0 - r_prod : r_prod;
    end

    assign o_vld  = r_vld[3];
    assign o_r    = $signed(r_res);
    assign o_pass = r_pass[3];

endmodule

FILE: hw/rtl/equatorial_to_horizontal.sv
// ----------------------------------------------------------------------------
// equatorial_to_horizontal
// declination and hour angle to azimuth and altitude for a fixed latitude
// ----------------------------------------------------------------------------
// Accepts one transaction every clock cycle; busy is never raised. Each result
// appears on o_azimuth/o_altitude with o_valid high for one cycle, once it has
// passed five cordic chains of CORDIC_STAGES cells plus a pre-step each, four
// 4-stage gain multipliers and one output register. Results cannot be held off.
// Write the latitude only while no transaction is in flight.
`include "equatorial_to_horizontal_defines.svh"

module equatorial_to_horizontal import e2h_pkg::*; #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_declination,
    input  logic [31:0]        i_hour_angle,
    input  logic               i_observer_latitude_we,
    input  logic signed [31:0] i_observer_latitude,
    output logic               o_valid,
    output logic [31:0]        o_azimuth,
    output logic signed [31:0] o_altitude
);

    localparam logic [63:0] ANGLE_MASK = ~64'd0 << (64 - ANGLE_BITS);
    localparam int          LAT        = 5 * (CORDIC_STAGES + 1) + 17;

    logic               accept;
    logic [63:0]        dec_q;
    logic [63:0]        ha_q;
    logic [63:0]        lat_q;
    logic [31:0]        r_lat;

    logic               a_vld;
    logic signed [63:0] a_x;
    logic signed [63:0] a_y;
    logic [63:0]        a_pass;
    logic               b_vld;
    logic signed [63:0] b_r;
    logic [127:0]       b_pass;
    logic               c_vld;
    logic signed [63:0] c_x;
    logic signed [63:0] c_y;
    logic [63:0]        c_pass;
    logic               d_vld;
    logic signed [63:0] d_r;
    logic [127:0]       d_pass;
    logic               e_vld;
    logic signed [63:0] e_r;
    logic [127:0]       e_pass;
    logic               f_vld;
    logic signed [63:0] f_x;
    logic signed [63:0] f_y;
    logic [63:0]        f_pass;
    logic               g_vld;
    logic signed [63:0] g_x;
    logic [63:0]        g_ang;
    logic [63:0]        g_pass;
    logic               h_vld;
    logic signed [63:0] h_r;
    logic [127:0]       h_pass;
    logic               k_vld;
    logic [63:0]        k_ang;
    logic [63:0]        k_pass;

    logic [63:0]        alt_c;
    logic [63:0]        az_rnd;
    logic [63:0]        alt_rnd;
    logic               r_valid;
    logic [31:0]        r_azimuth;
    logic [31:0]        r_altitude;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign dec_q = {i_declination, 32'd0} & ANGLE_MASK;
    assign ha_q  = {i_hour_angle, 32'd0} & ANGLE_MASK;
    assign lat_q = {r_lat, 32'd0} & ANGLE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= 32'd0;
        end else if (i_observer_latitude_we) begin
            r_lat <= i_observer_latitude;
        end
    end

    // (cos dec, sin dec)
    e2h_chain #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS), .PW(64)) u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(accept),
        .i_x(UNIT_Q60), .i_y(64'sd0), .i_ang(dec_q), .i_pass(ha_q),
        .o_vld(a_vld), .o_x(a_x), .o_y(a_y), .o_ang(), .o_pass(a_pass)
    );

    e2h_scale #(.PW(128)) u_scale_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(a_vld),
        .i_a(a_x), .i_pass({a_y, a_pass}),
        .o_vld(b_vld), .o_r(b_r), .o_pass(b_pass)
    );

    // turn by hour angle: (cos ha cos dec, sin ha cos dec)
    e2h_chain #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS), .PW(64)) u_ha (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(b_vld),
        .i_x(b_r), .i_y(64'sd0), .i_ang(b_pass[63:0]), .i_pass(b_pass[127:64]),
        .o_vld(c_vld), .o_x(c_x), .o_y(c_y), .o_ang(), .o_pass(c_pass)
    );

    e2h_scale #(.PW(128)) u_scale_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(c_vld),
        .i_a(c_x), .i_pass({c_y, c_pass}),
        .o_vld(d_vld), .o_r(d_r), .o_pass(d_pass)
    );

    e2h_scale #(.PW(128)) u_scale_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(d_vld),
        .i_a(d_pass[63:0]), .i_pass({d_r, d_pass[127:64]}),
        .o_vld(e_vld), .o_r(e_r), .o_pass(e_pass)
    );

    // tilt the x-z plane by the colatitude
    e2h_chain #(.VECTOR(1'b0), .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS), .PW(64)) u_lat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(e_vld),
        .i_x(e_pass[127:64]), .i_y(e_r), .i_ang(QUARTER_TURN - lat_q), .i_pass(e_pass[63:0]),
        .o_vld(f_vld), .o_x(f_x), .o_y(f_y), .o_ang(), .o_pass(f_pass)
    );

    // azimuth, half turn folded into the offset
    e2h_chain #(.VECTOR(1'b1), .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS), .PW(64)) u_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(f_vld),
        .i_x(f_x), .i_y(f_pass), .i_ang(HALF_TURN), .i_pass(f_y),
        .o_vld(g_vld), .o_x(g_x), .o_y(), .o_ang(g_ang), .o_pass(g_pass)
    );

    e2h_scale #(.PW(128)) u_scale_m (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(g_vld),
        .i_a(g_x), .i_pass({g_ang, g_pass}),
        .o_vld(h_vld), .o_r(h_r), .o_pass(h_pass)
    );

    // altitude as atan2(z, horizontal magnitude)
    e2h_chain #(.VECTOR(1'b1), .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS), .PW(64)) u_alt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(h_vld),
        .i_x(h_r), .i_y(h_pass[63:0]), .i_ang(64'd0), .i_pass(h_pass[127:64]),
        .o_vld(k_vld), .o_x(), .o_y(), .o_ang(k_ang), .o_pass(k_pass)
    );

    always_comb begin
        alt_c = k_ang;
        if (k_ang[63]) begin
            if ((64'd0 - k_ang) > QUARTER_TURN) begin
                alt_c = 64'd0 - QUARTER_TURN;
            end
        end else if (k_ang > QUARTER_TURN) begin
            alt_c = QUARTER_TURN;
        end
    end

    assign az_rnd  = k_pass + 64'h0000_0000_8000_0000;
    assign alt_rnd = alt_c + 64'h0000_0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_azimuth  <= az_rnd[63:32];
        r_altitude <= alt_rnd[63:32];
    end

    assign o_valid    = r_valid;
    assign o_azimuth  = r_azimuth;
    assign o_altitude = $signed(r_altitude);

    `E2H_ASSERT_AFTER(a_lat_hit, start && !busy, LAT, o_valid)
    `E2H_ASSERT_AFTER(a_lat_miss, !(start && !busy), LAT, !o_valid)
    `E2H_ASSERT_NOW(a_alt_range, o_valid, (o_altitude >= -32'sd1073741824) && (o_altitude <= 32'sd1073741824))

endmodule
